/* hw/rtl/u8dw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8dw_pkg - shared types and constants for the UTF-8 display width counter
// Holds the decoder state type, command and escape codes, and the
// combining-mark range check.
// ----------------------------------------------------------------------------
package u8dw_pkg;

  localparam int WIDTH_BITS = 16;    // result field width
  localparam int CODE_BITS  = 21;    // code point width
  localparam int ADD_BITS   = 3;     // columns added per word, at most 4

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_ESC  = 2'd1;
  localparam logic [1:0] PHASE_CSI  = 2'd2;

  localparam logic [7:0] BYTE_ESC     = 8'h1B;
  localparam logic [7:0] BYTE_BRACKET = 8'h5B;
  localparam logic [7:0] CSI_PARAM_LO = 8'h20;
  localparam logic [7:0] CSI_PARAM_HI = 8'h3F;
  localparam logic [7:0] CSI_FINAL_LO = 8'h40;
  localparam logic [7:0] CSI_FINAL_HI = 8'h7E;
  localparam logic [7:0] CONT_MASK    = 8'hC0;
  localparam logic [7:0] CONT_TAG     = 8'h80;

  typedef struct packed {
    logic [CODE_BITS-1:0] partial_code;
    logic [1:0]           bytes_pending;
    logic [1:0]           bytes_needed;
    logic [1:0]           escape_phase;
  } dec_state_t;

  function automatic logic zero_width(input logic [CODE_BITS-1:0] cp);
    zero_width = (cp >= 21'h0300 && cp <= 21'h036F) ||
                 (cp >= 21'h1AB0 && cp <= 21'h1AFF) ||
                 (cp >= 21'h1DC0 && cp <= 21'h1DFF) ||
                 (cp >= 21'h20D0 && cp <= 21'h20FF);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/utf8_display_width_counter_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_display_width_counter_top - UTF-8 display width counter
// Counts display columns of a byte string, skipping CSI escapes and
// zero-width combining marks; returns the width at the end word.
// ----------------------------------------------------------------------------
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_ready    in_command, in_data_byte
//   out_     out  out_valid/out_ready  out_display_width
//
// One word per cycle unless an end word stalls: an input register feeds
// the decoder step, whose result updates the state and the column count
// as the word leaves it; an end word also writes the output register then.
// Only an end word can stall, when the output register still holds an
// unread width; data words keep flowing while the width waits.
// Synchronous active-low reset returns to an empty string.
// ----------------------------------------------------------------------------
module utf8_display_width_counter_top #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_command,
  input  wire logic [7:0]                        in_data_byte,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [u8dw_pkg::WIDTH_BITS-1:0]        out_display_width
);
  import u8dw_pkg::*;

  logic                    s1_valid_r;
  logic                    s1_cmd_r;
  logic [7:0]              s1_byte_r;
  logic                    s1_fire;
  logic                    out_free;

  dec_state_t              st_r;
  dec_state_t              st_nxt;
  logic [ADD_BITS-1:0]     add_cols;

  logic [COUNT_BITS-1:0]   count_r;
  logic [COUNT_BITS-1:0]   count_nxt;
  logic [COUNT_BITS:0]     count_sum;
  logic [COUNT_BITS-1:0]   count_sat;
  logic [WIDTH_BITS-1:0]   width_sat;

  logic                    out_valid_r;
  logic [WIDTH_BITS-1:0]   out_width_r;

  u8dw_step u_step (
    .st        (st_r),
    .cmd       (s1_cmd_r),
    .data_byte (s1_byte_r),
    .st_nxt    (st_nxt),
    .add_cols  (add_cols)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && (s1_cmd_r == CMD_DATA || out_free);
  assign in_ready = !s1_valid_r || s1_fire;

  assign count_sum = {1'b0, count_r} + (COUNT_BITS + 1)'(add_cols);
  assign count_sat = count_sum[COUNT_BITS] ? '1 : count_sum[COUNT_BITS-1:0];
  assign count_nxt = (s1_cmd_r == CMD_END) ? '0 : count_sat;

  generate
    if (COUNT_BITS > WIDTH_BITS) begin : g_clip
      assign width_sat = (|count_sat[COUNT_BITS-1:WIDTH_BITS]) ? '1
                                                               : count_sat[WIDTH_BITS-1:0];
    end else begin : g_ext
      assign width_sat = WIDTH_BITS'(count_sat);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd_r  <= in_command;
      s1_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      count_r <= '0;
    end else if (s1_fire) begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_cmd_r == CMD_END) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // load the width when the end word retires
  always_ff @(posedge clk) begin
    if (s1_fire && s1_cmd_r == CMD_END) begin
      out_width_r <= width_sat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_display_width = out_width_r;

endmodule
`default_nettype wire

/* hw/rtl/u8dw_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8dw_step - per-word decoder step
// Combinational next state of the escape / UTF-8 decoder and the number of
// columns one word adds.
// ----------------------------------------------------------------------------
module u8dw_step (
  input  wire u8dw_pkg::dec_state_t         st,
  input  wire logic                         cmd,
  input  wire logic [7:0]                   data_byte,
  output u8dw_pkg::dec_state_t              st_nxt,
  output logic [u8dw_pkg::ADD_BITS-1:0]     add_cols
);
  import u8dw_pkg::*;

  dec_state_t           ns;
  logic                 fresh;
  logic [ADD_BITS-1:0]  add_a;
  logic [ADD_BITS-1:0]  add_b;
  logic [1:0]           pend_inc;
  logic [CODE_BITS-1:0] code_inc;

  always_comb begin
    ns       = st;
    fresh    = 1'b0;
    add_a    = '0;
    add_b    = '0;
    pend_inc = st.bytes_pending + 2'd1;
    code_inc = {st.partial_code[CODE_BITS-7:0], data_byte[5:0]};

    if (cmd == CMD_DATA) begin
      if (st.escape_phase == PHASE_ESC) begin
        ns.escape_phase = PHASE_IDLE;
        if (data_byte == BYTE_BRACKET) begin
          ns.escape_phase = PHASE_CSI;
        end else begin
          add_a = ADD_BITS'(1);
          fresh = 1'b1;
        end
      end else if (st.escape_phase == PHASE_CSI) begin
        if (!(data_byte >= CSI_PARAM_LO && data_byte <= CSI_PARAM_HI)) begin
          ns.escape_phase = PHASE_IDLE;
          fresh = !(data_byte >= CSI_FINAL_LO && data_byte <= CSI_FINAL_HI);
        end
      end else if (st.bytes_needed != 2'd0) begin
        if ((data_byte & CONT_MASK) == CONT_TAG) begin
          ns.partial_code  = code_inc;
          ns.bytes_pending = pend_inc;
          if (pend_inc >= st.bytes_needed) begin
            if (!zero_width(code_inc)) add_a = ADD_BITS'(1);
            ns.partial_code  = '0;
            ns.bytes_pending = 2'd0;
            ns.bytes_needed  = 2'd0;
          end
        end else begin
          // broken sequence: lead plus received continuations, one column each
          add_a            = ADD_BITS'(1) + ADD_BITS'(st.bytes_pending);
          ns.partial_code  = '0;
          ns.bytes_pending = 2'd0;
          ns.bytes_needed  = 2'd0;
          fresh            = 1'b1;
        end
      end else begin
        fresh = 1'b1;
      end

      // handle the byte with nothing open
      if (fresh) begin
        if (data_byte == BYTE_ESC) begin
          ns.escape_phase = PHASE_ESC;
        end else if (data_byte[7] == 1'b0) begin
          add_b = ADD_BITS'(1);
        end else if (data_byte[7:5] == 3'b110) begin
          ns.bytes_needed  = 2'd1;
          ns.bytes_pending = 2'd0;
          ns.partial_code  = CODE_BITS'(data_byte[4:0]);
        end else if (data_byte[7:4] == 4'b1110) begin
          ns.bytes_needed  = 2'd2;
          ns.bytes_pending = 2'd0;
          ns.partial_code  = CODE_BITS'(data_byte[3:0]);
        end else if (data_byte[7:3] == 5'b11110) begin
          ns.bytes_needed  = 2'd3;
          ns.bytes_pending = 2'd0;
          ns.partial_code  = CODE_BITS'(data_byte[2:0]);
        end else begin
          add_b = ADD_BITS'(1);
        end
      end
    end else begin
      if (st.escape_phase == PHASE_ESC) begin
        add_a = ADD_BITS'(1);
      end else if (st.escape_phase == PHASE_IDLE && st.bytes_needed != 2'd0) begin
        add_a = ADD_BITS'(1) + ADD_BITS'(st.bytes_pending);
      end
      ns.partial_code  = '0;
      ns.bytes_pending = 2'd0;
      ns.bytes_needed  = 2'd0;
      ns.escape_phase  = PHASE_IDLE;
    end
  end

  assign st_nxt   = ns;
  assign add_cols = add_a + add_b;

endmodule
`default_nettype wire

/* bench/tb_utf8_display_width_counter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_display_width_counter_top - self-checking bench for the width counter
// Streams byte strings and end words into the counter, predicts each string's
// column count with a local UTF-8 / CSI decoder, and checks every returned
// width in order. Directed strings first, then random strings built from
// well-formed escapes and sequences mixed with broken ones and noise.
// ----------------------------------------------------------------------------
module tb_utf8_display_width_counter_top;
  import u8dw_pkg::*;

  localparam int          STALL_LIMIT = 3000;
  localparam int          TAIL_CYCLES = 10;
  localparam int          MAX_PRINTS  = 40;
  localparam logic [15:0] WIDTH_MAX   = 16'hFFFF;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_display_width;

  utf8_display_width_counter_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_display_width (out_display_width)
  );

  // Decoder state mirrored from the block
  logic [CODE_BITS-1:0] code_acc;
  logic [1:0]           cont_seen;
  logic [1:0]           cont_want;
  logic [1:0]           esc_state;
  logic [15:0]          col_total;

  logic [15:0] width_q [$];
  logic [7:0]  str_bytes [$];
  logic [15:0] exp_width;
  int          err_count;
  int          words_sent;
  int          quiet_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  b;
    logic        lit_ok;
    logic [15:0] lit;
  } dir_row_t;

  dir_row_t dir_rows [25] = '{
    '{CMD_END,  8'h00, 1'b1, 16'd0},  // empty string right after reset
    '{CMD_DATA, 8'h00, 1'b0, 16'd0},
    '{CMD_DATA, 8'h7F, 1'b0, 16'd0},
    '{CMD_DATA, 8'hFF, 1'b0, 16'd0},  // invalid lead
    '{CMD_DATA, 8'h80, 1'b0, 16'd0},  // stray continuation
    '{CMD_END,  8'hFF, 1'b1, 16'd4},
    '{CMD_DATA, 8'h1B, 1'b0, 16'd0},
    '{CMD_DATA, 8'h5B, 1'b0, 16'd0},
    '{CMD_DATA, 8'h30, 1'b0, 16'd0},
    '{CMD_DATA, 8'h7E, 1'b0, 16'd0},  // highest final byte closes the CSI
    '{CMD_DATA, 8'h1B, 1'b0, 16'd0},
    '{CMD_DATA, 8'h41, 1'b0, 16'd0},  // lone ESC, letter handled afresh
    '{CMD_END,  8'h00, 1'b0, 16'd0},
    '{CMD_DATA, 8'hCC, 1'b0, 16'd0},
    '{CMD_DATA, 8'h80, 1'b0, 16'd0},  // combining grave, zero columns
    '{CMD_DATA, 8'hE2, 1'b0, 16'd0},
    '{CMD_DATA, 8'h41, 1'b0, 16'd0},  // breaks the three-byte sequence
    '{CMD_DATA, 8'hF0, 1'b0, 16'd0},
    '{CMD_DATA, 8'h9F, 1'b0, 16'd0},
    '{CMD_END,  8'h00, 1'b0, 16'd0},  // cut short inside a four-byte sequence
    '{CMD_DATA, 8'h1B, 1'b0, 16'd0},
    '{CMD_DATA, 8'h5B, 1'b0, 16'd0},
    '{CMD_DATA, 8'h0A, 1'b0, 16'd0},  // unclosed CSI, newline counts
    '{CMD_DATA, 8'h1B, 1'b0, 16'd0},
    '{CMD_END,  8'h00, 1'b1, 16'd2}   // ESC as last byte counts one
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void add_cols(input int n);
    int s;
    s = int'(col_total) + n;
    col_total = (s > int'(WIDTH_MAX)) ? WIDTH_MAX : s[15:0];
  endfunction

  function automatic logic is_combining(input logic [CODE_BITS-1:0] cp);
    return (cp >= 21'h0300 && cp <= 21'h036F) || (cp >= 21'h1AB0 && cp <= 21'h1AFF) ||
           (cp >= 21'h1DC0 && cp <= 21'h1DFF) || (cp >= 21'h20D0 && cp <= 21'h20FF);
  endfunction

  function automatic void clear_seq();
    code_acc  = '0;
    cont_seen = 2'd0;
    cont_want = 2'd0;
  endfunction

  // Returns 1 when the byte is absorbed by the open escape or sequence
  function automatic logic open_step(input logic [7:0] b);
    if (esc_state == PHASE_ESC) begin
      esc_state = PHASE_IDLE;
      if (b == BYTE_BRACKET) begin
        esc_state = PHASE_CSI;
        return 1'b1;
      end
      add_cols(1);
      return 1'b0;
    end
    if (esc_state == PHASE_CSI) begin
      if (b >= CSI_PARAM_LO && b <= CSI_PARAM_HI) return 1'b1;
      esc_state = PHASE_IDLE;
      return (b >= CSI_FINAL_LO && b <= CSI_FINAL_HI);
    end
    if ((b & CONT_MASK) == CONT_TAG) begin
      code_acc  = {code_acc[CODE_BITS-7:0], b[5:0]};
      cont_seen = cont_seen + 2'd1;
      if (cont_seen >= cont_want) begin
        if (!is_combining(code_acc)) add_cols(1);
        clear_seq();
      end
      return 1'b1;
    end
    add_cols(1 + int'(cont_seen));
    clear_seq();
    return 1'b0;
  endfunction

  function automatic void fresh_step(input logic [7:0] b);
    if (b == BYTE_ESC) begin
      esc_state = PHASE_ESC;
    end else if (!b[7]) begin
      add_cols(1);
    end else if (b[7:5] == 3'b110) begin
      cont_want = 2'd1;
      cont_seen = 2'd0;
      code_acc  = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      cont_want = 2'd2;
      cont_seen = 2'd0;
      code_acc  = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      cont_want = 2'd3;
      cont_seen = 2'd0;
      code_acc  = {18'd0, b[2:0]};
    end else begin
      add_cols(1);
    end
  endfunction

  function automatic void reset_width_state();
    clear_seq();
    esc_state = PHASE_IDLE;
    col_total = 16'd0;
  endfunction

  task automatic predict_word(input logic cmd, input logic [7:0] b,
                              output logic has_width, output logic [15:0] width);
    has_width = 1'b0;
    width     = 16'd0;
    if (cmd == CMD_DATA) begin
      if (esc_state != PHASE_IDLE || cont_want != 2'd0) begin
        if (!open_step(b)) fresh_step(b);
      end else begin
        fresh_step(b);
      end
    end else begin
      if (esc_state == PHASE_ESC) add_cols(1);
      else if (esc_state == PHASE_IDLE && cont_want != 2'd0) add_cols(1 + int'(cont_seen));
      has_width = 1'b1;
      width     = col_total;
      reset_width_state();
    end
  endtask

  // ------------------------------------------------------------------ driving
  task automatic send_word(input logic cmd, input logic [7:0] b,
                           input logic lit_ok, input logic [15:0] lit);
    logic        has_width;
    logic [15:0] width;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(cmd, b, has_width, width);
    if (has_width) width_q.push_back(lit_ok ? lit : width);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (width_q.size() != 0) @(negedge clk);
  endtask

  task automatic put_utf8(input logic [CODE_BITS-1:0] cp, input int len);
    case (len)
      2: begin
        str_bytes.push_back({3'b110, cp[10:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        str_bytes.push_back({4'b1110, cp[15:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        str_bytes.push_back({5'b11110, cp[20:18]});
        str_bytes.push_back({2'b10, cp[17:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic put_lead_only(input int len, input int conts);
    case (len)
      2:       str_bytes.push_back({3'b110, 5'($urandom)});
      3:       str_bytes.push_back({4'b1110, 4'($urandom)});
      default: str_bytes.push_back({5'b11110, 3'($urandom)});
    endcase
    repeat (conts) str_bytes.push_back({2'b10, 6'($urandom)});
  endtask

  task automatic put_csi_params();
    repeat ($urandom_range(0, 4))
      str_bytes.push_back(8'($urandom_range(CSI_PARAM_LO, CSI_PARAM_HI)));
  endtask

  task automatic build_string();
    logic [7:0]           nb;
    logic [CODE_BITS-1:0] cp;
    int                   len;
    int                   pick;
    str_bytes.delete();
    repeat ($urandom_range(0, 12)) begin
      case ($urandom_range(0, 11))
        0, 1: str_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
        2:    str_bytes.push_back(8'($urandom_range(0, 8'h7F)));
        3: begin
          str_bytes.push_back(BYTE_ESC);
          str_bytes.push_back(BYTE_BRACKET);
          put_csi_params();
          str_bytes.push_back(8'($urandom_range(CSI_FINAL_LO, CSI_FINAL_HI)));
        end
        4:    str_bytes.push_back(BYTE_ESC);
        5, 6: put_utf8(21'($urandom), $urandom_range(2, 4));
        7: begin
          // combining ranges plus their neighbors, overlong forms included
          pick = $urandom_range(0, 3);
          case (pick)
            0:       cp = 21'($urandom_range(21'h02FF, 21'h0370));
            1:       cp = 21'($urandom_range(21'h1AAF, 21'h1B00));
            2:       cp = 21'($urandom_range(21'h1DBF, 21'h1E00));
            default: cp = 21'($urandom_range(21'h20CF, 21'h2100));
          endcase
          put_utf8(cp, (cp < 21'h0800) ? $urandom_range(2, 4) : $urandom_range(3, 4));
        end
        8: begin
          len = $urandom_range(2, 4);
          put_lead_only(len, $urandom_range(0, len - 2));
          nb = 8'($urandom);
          if ((nb & CONT_MASK) == CONT_TAG) nb[6] = 1'b1;
          str_bytes.push_back(nb);
        end
        9: str_bytes.push_back($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                 : 8'($urandom_range(8'hF8, 8'hFF)));
        10: begin
          str_bytes.push_back(BYTE_ESC);
          str_bytes.push_back(BYTE_BRACKET);
          put_csi_params();
          str_bytes.push_back($urandom_range(1) ? 8'($urandom_range(0, 8'h1F))
                                                : 8'($urandom_range(8'h7F, 8'hFF)));
        end
        default: str_bytes.push_back(8'($urandom));
      endcase
    end
    // leave something open at the end now and then
    case ($urandom_range(0, 7))
      0: begin
        len = $urandom_range(2, 4);
        put_lead_only(len, $urandom_range(0, len - 2));
      end
      1: str_bytes.push_back(BYTE_ESC);
      2: begin
        str_bytes.push_back(BYTE_ESC);
        str_bytes.push_back(BYTE_BRACKET);
        put_csi_params();
      end
      default: ;
    endcase
  endtask

  task automatic run_strings(input int n_words);
    int stop_at;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      build_string();
      foreach (str_bytes[i]) send_word(CMD_DATA, str_bytes[i], 1'b0, 16'd0);
      send_word(CMD_END, 8'($urandom), 1'b0, 16'd0);
    end
  endtask

  // ----------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("%0t: mismatch, %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (width_q.size() == 0) begin
        report_mismatch("width with none pending", out_display_width, 16'd0);
      end else begin
        exp_width = width_q.pop_front();
        if (out_display_width !== exp_width)
          report_mismatch("display_width", out_display_width, exp_width);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ----------------------------------------------------------------- sequence
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = CMD_DATA;
    in_data_byte  = 8'h00;
    out_ready     = 1'b0;
    err_count     = 0;
    words_sent    = 0;
    quiet_cycles  = 0;
    send_idle_pct = 13;
    recv_idle_pct = 47;
    reset_width_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].cmd, dir_rows[i].b, dir_rows[i].lit_ok, dir_rows[i].lit);
    run_strings(400);
    hold_until_drained();

    send_idle_pct = 47;
    recv_idle_pct = 13;
    run_strings(400);
    hold_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_strings(400);

    hold_until_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
